@@ sv/kpec_pkg.sv @@
`timescale 1ns / 1ps
// Package for the key press event classifier: beat types, codes and constants.
// Depends on nothing; every other file of the block imports it.
package kpec_pkg;

  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 32;
  localparam logic [15:0] REPEAT_TICKS = 16'd250;

  localparam logic [15:0] LONG_PRESS_RESET   = 16'd400;
  localparam logic [15:0] DOUBLE_PRESS_RESET = 16'd0;
  localparam logic [7:0]  CHANNEL_RESET      = 8'd1;

  typedef enum logic {
    FUNC_TICK = 1'b0,
    FUNC_POLL = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    PIN_HELD     = 2'd0,
    PIN_IDLE     = 2'd1,
    PIN_PRESSED  = 2'd2,
    PIN_RELEASED = 2'd3
  } pin_t;

  typedef enum logic [1:0] {
    EV_SHORT_SINGLE = 2'd0,
    EV_SHORT_DOUBLE = 2'd1,
    EV_REPEAT_LONG  = 2'd2,
    EV_LONG_RELEASE = 2'd3
  } event_t;

  typedef enum logic [1:0] {
    REG_LONG_PRESS   = 2'd0,
    REG_DOUBLE_PRESS = 2'd1,
    REG_CHANNEL      = 2'd2,
    REG_NONE         = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic       func;
    logic [1:0] pin_status;
    logic       low_battery;
  } key_item_t;

  typedef struct packed {
    logic [1:0] event_code;
    logic       long_flag;
    logic [7:0] channel_out;
    logic       battery_flag;
    logic [7:0] press_count;
    logic       final_flag;
  } key_event_t;

  typedef struct packed {
    logic [15:0] long_press_ticks;
    logic [15:0] double_press_ticks;
    logic [7:0]  channel_number;
  } kpec_cfg_t;

endpackage

@@ sv/kpec_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for key poll items and key events.
// Depends on kpec_pkg for the beat types.
interface kpec_item_if;
  import kpec_pkg::*;

  logic      valid;
  logic      ready;
  key_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface kpec_event_if;
  import kpec_pkg::*;

  logic       valid;
  logic       ready;
  key_event_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ sv/kpec_regs.sv @@
`timescale 1ns / 1ps
// APB register bank holding the timing and channel settings of the classifier.
// Depends on kpec_pkg for the register indexes and the settings struct.
module kpec_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [kpec_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [kpec_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [kpec_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready,
  output kpec_pkg::kpec_cfg_t                 cfg
);
  import kpec_pkg::*;

  reg_index_t index;
  logic       write_en;

  assign pready   = 1'b1;
  assign index    = reg_index_t'(paddr[3:2]);
  assign write_en = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.long_press_ticks   <= LONG_PRESS_RESET;
      cfg.double_press_ticks <= DOUBLE_PRESS_RESET;
      cfg.channel_number     <= CHANNEL_RESET;
    end else if (write_en) begin
      case (index)
        REG_LONG_PRESS:   cfg.long_press_ticks   <= pwdata[15:0];
        REG_DOUBLE_PRESS: cfg.double_press_ticks <= pwdata[15:0];
        REG_CHANNEL:      cfg.channel_number     <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (index)
      REG_LONG_PRESS:   prdata = {16'd0, cfg.long_press_ticks};
      REG_DOUBLE_PRESS: prdata = {16'd0, cfg.double_press_ticks};
      REG_CHANNEL:      prdata = {24'd0, cfg.channel_number};
      default:          prdata = '0;
    endcase
  end

endmodule

@@ sv/key_press_event_classifier_core.sv @@
`timescale 1ns / 1ps
// Top level of the key press event classifier: key state, timer and event register.
// Depends on kpec_pkg, the channel interfaces in kpec_if and the register bank kpec_regs.
//
// Use: each beat on the item channel is either a time tick, which counts the key
// timer down towards zero, or a poll carrying the pin status. A poll may cause one
// beat on the event channel: short single, short double, repeated long or long
// release, with the channel number, the battery flag and the press counter.
// Ticks never cause an event beat.
// An event appears on the event channel in the cycle after the poll that caused
// it is accepted. One item is accepted per cycle while no event is stalled; the
// rate is set by the single event register, which may be refilled in the cycle it
// empties. While the receiver stalls with an event waiting, the item channel stops
// taking beats, so no event is lost or overwritten.
// The settings are written over the APB port at byte addresses 0, 4 and 8; the user
// must write them only while the block is idle, which the block does not enforce.
// pready is always high. Reset clears the timer, the key flags and the press counter,
// loads the settings with their defaults and empties the event register.
module key_press_event_classifier_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [kpec_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [kpec_pkg::APB_DATA_W-1:0] pwdata,
  output logic [kpec_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready,
  kpec_item_if.sink                       item,
  kpec_event_if.source                    result
);
  import kpec_pkg::*;

  kpec_cfg_t   cfg;
  logic [15:0] countdown;
  logic [15:0] countdown_next;
  logic        armed;
  logic        armed_next;
  logic        was_long;
  logic        was_long_next;
  logic        was_short;
  logic        was_short_next;
  logic [7:0]  event_counter;
  logic [7:0]  event_counter_next;
  logic        fire;
  logic        emit;
  event_t      kind;

  kpec_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign item.ready = !result.valid || result.ready;
  assign fire       = item.valid && item.ready;

  always_comb begin
    countdown_next     = countdown;
    armed_next         = armed;
    was_long_next      = was_long;
    was_short_next     = was_short;
    event_counter_next = event_counter;
    emit               = 1'b0;
    kind               = EV_SHORT_SINGLE;
    if (fire) begin
      if (item.data.func == FUNC_TICK) begin
        if (countdown != 16'd0) begin
          countdown_next = countdown - 16'd1;
        end
      end else begin
        if (item.data.pin_status == PIN_PRESSED) begin
          countdown_next = cfg.long_press_ticks;
          armed_next     = 1'b1;
        end
        if (armed_next) begin
          if (item.data.pin_status == PIN_RELEASED) begin
            countdown_next = cfg.double_press_ticks;
            if (was_long) begin
              kind = EV_LONG_RELEASE;
              emit = 1'b1;
            end else if (was_short) begin
              was_short_next = 1'b0;
              kind           = EV_SHORT_DOUBLE;
              emit           = 1'b1;
            end else begin
              was_short_next = 1'b1;
              kind           = EV_SHORT_SINGLE;
              emit           = (cfg.double_press_ticks == 16'd0);
            end
            was_long_next = 1'b0;
          end
          if (countdown_next == 16'd0) begin
            case (item.data.pin_status)
              PIN_HELD: begin
                countdown_next = REPEAT_TICKS;
                was_long_next  = 1'b1;
                kind           = EV_REPEAT_LONG;
                emit           = 1'b1;
              end
              PIN_IDLE: begin
                armed_next     = 1'b0;
                was_long_next  = 1'b0;
                was_short_next = 1'b0;
              end
              default: ;
            endcase
          end
        end
      end
    end
    if (emit && (kind != EV_REPEAT_LONG)) begin
      event_counter_next = event_counter + 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      countdown     <= '0;
      armed         <= 1'b0;
      was_long      <= 1'b0;
      was_short     <= 1'b0;
      event_counter <= '0;
      result.valid  <= 1'b0;
    end else begin
      countdown     <= countdown_next;
      armed         <= armed_next;
      was_long      <= was_long_next;
      was_short     <= was_short_next;
      event_counter <= event_counter_next;
      if (emit) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result.data.event_code   <= kind;
      result.data.long_flag    <= (kind == EV_REPEAT_LONG) || (kind == EV_LONG_RELEASE);
      result.data.channel_out  <= cfg.channel_number;
      result.data.battery_flag <= item.data.low_battery;
      result.data.press_count  <= event_counter;
      result.data.final_flag   <= (kind != EV_REPEAT_LONG);
    end
  end

  // A waiting event must hold back the item channel so that it is never overwritten.
  assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.ready) |-> !item.ready)
    else $error("item accepted while an event was stalled");

  // A long event carries the long flag, and only a repeated long is not final.
  assert property (@(posedge clk) disable iff (rst)
    result.valid |-> ((result.data.long_flag == result.data.event_code[1]) &&
                      (result.data.final_flag ==
                       (result.data.event_code != EV_REPEAT_LONG))))
    else $error("inconsistent flags on an event beat");

  // A tick never produces an event beat.
  assert property (@(posedge clk) disable iff (rst)
    (fire && (item.data.func == FUNC_TICK) && !result.valid) |=> !result.valid)
    else $error("event beat produced by a tick");

  // The press counter moves only with a final event.
  assert property (@(posedge clk) disable iff (rst)
    (event_counter_next != event_counter) |-> (emit && (kind != EV_REPEAT_LONG)))
    else $error("press counter moved without a final event");

  // A disarmed key keeps no long or short history.
  assert property (@(posedge clk) disable iff (rst)
    !armed |-> (!was_long && !was_short))
    else $error("key history kept while disarmed");

endmodule
